>>> design/conjugate_gradient_solver_assert.svh
// Assertion macros used by the solver top level.
`ifndef CONJUGATE_GRADIENT_SOLVER_ASSERT_SVH
`define CONJUGATE_GRADIENT_SOLVER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CGS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define CGS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/cgs_pkg.sv
// Shared types, codes and helpers of the conjugate gradient solver.
package cgs_pkg;

	localparam int VAL_W     = 32;
	localparam int ACC_W     = 64;
	localparam int FIELD_W   = 3;
	localparam int CFG_IDX_W = 8;

	localparam logic [1:0] FUNC_LOAD_A = 2'd0;
	localparam logic [1:0] FUNC_LOAD_B = 2'd1;
	localparam logic [1:0] FUNC_START  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EPS      = 8'd1;

	localparam logic [1:0] SRC_R = 2'd0;
	localparam logic [1:0] SRC_P = 2'd1;

	localparam logic [1:0] DST_AR = 2'd0;
	localparam logic [1:0] DST_AP = 2'd1;

	localparam logic [1:0] DOT_RR  = 2'd0;
	localparam logic [1:0] DOT_PAP = 2'd1;
	localparam logic [1:0] DOT_PAR = 2'd2;
	localparam logic [1:0] DOT_PR  = 2'd3;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_WRA,
		OP_WRB,
		OP_INIT,
		OP_LOADV,
		OP_MAC,
		OP_STORE,
		OP_DOT,
		OP_SHIFT,
		OP_MULP,
		OP_WRP,
		OP_MULX,
		OP_WRX,
		OP_MULR,
		OP_WRR,
		OP_SHIFTX
	} cell_op_t;

	typedef struct packed {
		cell_op_t                  op;
		logic [1:0]                sel;
		logic [FIELD_W-1:0]        row;
		logic [FIELD_W-1:0]        col;
		logic signed [VAL_W-1:0]   scalar;
	} cgs_ctrl_t;

	function automatic logic signed [VAL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(64'sh0000_0000_7FFF_FFFF);
		lo = ACC_W'(-64'sh0000_0000_8000_0000);
		if (v > hi) begin
			return VAL_W'(hi);
		end else if (v < lo) begin
			return VAL_W'(lo);
		end
		return v[VAL_W-1:0];
	endfunction

endpackage

>>> design/cgs_cell.sv
// One solver cell: a matrix row, one element of each vector and a multiplier.
module cgs_cell
	import cgs_pkg::*;
#(
	parameter int DIM       = 8,
	parameter int FRAC_BITS = 16,
	parameter int CELL_IDX  = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cgs_ctrl_t                ctrl,
	input  logic signed [VAL_W-1:0]  v_in,
	output logic signed [VAL_W-1:0]  v_out,
	input  logic signed [ACC_W-1:0]  t_in,
	output logic signed [ACC_W-1:0]  t_out,
	input  logic signed [VAL_W-1:0]  x_in,
	output logic signed [VAL_W-1:0]  x_out
);

	localparam int CW = (DIM > 1) ? $clog2(DIM) : 1;

	logic signed [VAL_W-1:0] row_mem [DIM];
	logic signed [VAL_W-1:0] rd_q;
	logic [CW-1:0]           col_q;

	logic signed [VAL_W-1:0] x_q, r_q, p_q, ap_q, ar_q, rhs_q, v_q;
	logic signed [VAL_W-1:0] a_s1, b_s1;
	logic                    mul_s1, mac_s1, mul_s2, mac_s2;
	logic signed [ACC_W-1:0] prod_s2;
	logic signed [ACC_W-1:0] acc_q, term_q;
	logic signed [ACC_W-1:0] prod_sh;
	logic signed [VAL_W-1:0] mul_a;
	logic                    row_hit;
	logic                    wr_a;

	assign row_hit = (32'(ctrl.row) == CELL_IDX);
	assign wr_a    = (ctrl.op == OP_WRA) && row_hit && (32'(ctrl.col) < DIM);
	assign mul_a   = mac_s1 ? rd_q : a_s1;
	assign prod_sh = prod_s2 >>> FRAC_BITS;

	assign v_out = v_q;
	assign t_out = term_q;
	assign x_out = x_q;

	always_ff @(posedge clk) begin
		if (wr_a) begin
			row_mem[CW'(ctrl.col)] <= ctrl.scalar;
		end
		if (ctrl.op == OP_MAC) begin
			rd_q <= row_mem[col_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_s1 <= 1'b0;
			mac_s1 <= 1'b0;
			mul_s2 <= 1'b0;
			mac_s2 <= 1'b0;
			col_q  <= '0;
		end else begin
			mul_s1 <= (ctrl.op == OP_MAC) || (ctrl.op == OP_DOT) || (ctrl.op == OP_MULP) ||
				(ctrl.op == OP_MULX) || (ctrl.op == OP_MULR);
			mac_s1 <= (ctrl.op == OP_MAC);
			mul_s2 <= mul_s1;
			mac_s2 <= mac_s1;
			if (ctrl.op == OP_LOADV) begin
				col_q <= CW'(CELL_IDX);
			end else if (ctrl.op == OP_MAC) begin
				col_q <= (32'(col_q) == DIM - 1) ? '0 : col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= ACC_W'(mul_a) * ACC_W'(b_s1);
		if (mul_s2) begin
			if (mac_s2) begin
				acc_q <= acc_q + prod_sh;
			end else begin
				term_q <= prod_sh;
			end
		end
		case (ctrl.op)
			OP_WRB: begin
				if (row_hit) begin
					rhs_q <= ctrl.scalar;
				end
			end
			OP_INIT: begin
				x_q  <= '0;
				r_q  <= rhs_q;
				p_q  <= rhs_q;
				ap_q <= '0;
			end
			OP_LOADV: begin
				v_q   <= (ctrl.sel == SRC_P) ? p_q : r_q;
				acc_q <= '0;
			end
			OP_MAC: begin
				b_s1 <= v_q;
				v_q  <= v_in;
			end
			OP_STORE: begin
				if (ctrl.sel == DST_AP) begin
					ap_q <= sat32(acc_q);
				end else begin
					ar_q <= sat32(acc_q);
				end
			end
			OP_DOT: begin
				case (ctrl.sel)
					DOT_RR: begin
						a_s1 <= r_q;
						b_s1 <= r_q;
					end
					DOT_PAP: begin
						a_s1 <= p_q;
						b_s1 <= ap_q;
					end
					DOT_PAR: begin
						a_s1 <= p_q;
						b_s1 <= ar_q;
					end
					default: begin
						a_s1 <= p_q;
						b_s1 <= r_q;
					end
				endcase
			end
			OP_SHIFT: begin
				term_q <= t_in;
			end
			OP_MULP, OP_MULX: begin
				a_s1 <= ctrl.scalar;
				b_s1 <= p_q;
			end
			OP_MULR: begin
				a_s1 <= ctrl.scalar;
				b_s1 <= ap_q;
			end
			OP_WRP: begin
				p_q <= sat32(ACC_W'(r_q) + term_q);
			end
			OP_WRX: begin
				x_q <= sat32(ACC_W'(x_q) + term_q);
			end
			OP_WRR: begin
				r_q <= sat32(ACC_W'(r_q) - term_q);
			end
			OP_SHIFTX: begin
				x_q <= x_in;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> design/cgs_div.sv
// Serial restoring divider for the fixed-point step quotients.
module cgs_div
	import cgs_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [ACC_W-1:0]  num,
	input  logic signed [ACC_W-1:0]  den,
	output logic                     busy,
	output logic                     done,
	output logic signed [VAL_W-1:0]  quo
);

	localparam int DW = ACC_W + FRAC_BITS;
	localparam int NW = $clog2(DW + 1);

	logic [DW-1:0]    q_q;
	logic [ACC_W:0]   rem_q;
	logic [ACC_W-1:0] ud_q;
	logic             neg_q;
	logic [NW-1:0]    cnt_q;
	logic [ACC_W:0]   rem_sh;
	logic [ACC_W:0]   rem_sub;
	logic [ACC_W-1:0] un, ud;
	logic             sat;
	logic [VAL_W-1:0] q_lo;

	assign un      = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
	assign ud      = den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
	assign rem_sh  = {rem_q[ACC_W-1:0], q_q[DW-1]};
	assign rem_sub = rem_sh - {1'b0, ud_q};
	assign sat     = |q_q[DW-1:VAL_W-1];
	assign q_lo    = {1'b0, q_q[VAL_W-2:0]};

	always_comb begin
		if (sat) begin
			quo = neg_q ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
		end else begin
			quo = neg_q ? VAL_W'(-q_lo) : q_lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			done  <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy  <= 1'b1;
				cnt_q <= NW'(DW);
			end else if (busy) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == NW'(1)) begin
					busy <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= {un, {FRAC_BITS{1'b0}}};
			rem_q <= '0;
			ud_q  <= ud;
			neg_q <= num[ACC_W-1] ^ den[ACC_W-1];
		end else if (busy) begin
			if (!rem_sub[ACC_W]) begin
				rem_q <= rem_sub;
				q_q   <= {q_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				q_q   <= {q_q[DW-2:0], 1'b0};
			end
		end
	end

endmodule

>>> design/conjugate_gradient_solver.sv
// Top level of the conjugate gradient solver: sequencer, cell row and divider.
//
//  channel | direction | handshake         | payload
//  s_*     | in        | s_tvalid/s_tready | s_tuser func, s_tdata row,col,value
//  m_*     | out       | m_tvalid/m_tready | m_tdata index,solution,passes; tuser; tlast
//  cfg_*   | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Loads are written straight into the cells while idle. A solve runs per pass
// ring matrix-vector products, dot-product shifts down the cell row and
// divisions in the serial divider, plus update steps.
// Results follow at one per cycle while m_tready is high; s_tready stays low
// from a start request until the last result is taken. Reset is asynchronous
// and needs no clearing pass; configuration writes are taken only while idle.
module conjugate_gradient_solver
	import cgs_pkg::*;
#(
	parameter int DIM       = 8,
	parameter int FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [39:0]           s_tdata,   // row[2:0], col[5:3], value[37:6]
	input  logic [1:0]            s_tuser,   // func[1:0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [55:0]           m_tdata,   // index[2:0], solution[34:3], passes[50:35]
	output logic                  m_tuser,   // converged[0]
	output logic                  m_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [VAL_W-1:0]      cfg_data
);

	`include "conjugate_gradient_solver_assert.svh"

	localparam int CW = (DIM > 1) ? $clog2(DIM) : 1;

	typedef enum logic [4:0] {
		S_IDLE, S_INIT, S_DOT, S_DSHIFT, S_LOADV, S_MAC, S_STORE, S_DIV, S_DIVWAIT,
		S_MULP, S_WRP, S_MULX, S_WRX, S_MULR, S_WRR, S_WAIT, S_EMIT
	} state_t;

	state_t                  state_q, ret_q;
	logic [CW-1:0]           cnt_q, idx_q;
	logic [1:0]              dsel_q;
	logic                    gam_q, conv_q;
	logic [15:0]             pass_q, maxit_q;
	logic [VAL_W-1:0]        eps_q;
	logic signed [ACC_W-1:0] acc_q, num_q, den_q, dsum;
	logic signed [VAL_W-1:0] scal_q;
	cgs_ctrl_t               ctrl;

	logic signed [VAL_W-1:0] v_o [DIM];
	logic signed [ACC_W-1:0] t_o [DIM];
	logic signed [VAL_W-1:0] x_o [DIM];

	logic                    div_start, div_busy, div_done;
	logic signed [VAL_W-1:0] div_quo;
	logic                    rr_ok;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign m_tvalid  = (state_q == S_EMIT);
	assign m_tdata   = {5'b0, pass_q, x_o[0], FIELD_W'(idx_q)};
	assign m_tuser   = conv_q;
	assign m_tlast   = (32'(idx_q) == DIM - 1);
	assign div_start = (state_q == S_DIV);
	assign dsum      = acc_q + t_o[0];
	assign rr_ok     = (dsum <= $signed({32'b0, eps_q}));

	always_comb begin
		ctrl.op     = OP_NOP;
		ctrl.sel    = dsel_q;
		ctrl.row    = s_tdata[2:0];
		ctrl.col    = s_tdata[5:3];
		ctrl.scalar = scal_q;
		case (state_q)
			S_IDLE: begin
				ctrl.scalar = s_tdata[37:6];
				if (s_tvalid && s_tuser == FUNC_LOAD_A) begin
					ctrl.op = OP_WRA;
				end else if (s_tvalid && s_tuser == FUNC_LOAD_B) begin
					ctrl.op = OP_WRB;
				end
			end
			S_INIT:   ctrl.op = OP_INIT;
			S_DOT:    ctrl.op = OP_DOT;
			S_DSHIFT: ctrl.op = OP_SHIFT;
			S_LOADV: begin
				ctrl.op  = OP_LOADV;
				ctrl.sel = gam_q ? SRC_R : SRC_P;
			end
			S_MAC:    ctrl.op = OP_MAC;
			S_STORE: begin
				ctrl.op  = OP_STORE;
				ctrl.sel = gam_q ? DST_AR : DST_AP;
			end
			S_MULP:   ctrl.op = OP_MULP;
			S_WRP:    ctrl.op = OP_WRP;
			S_MULX:   ctrl.op = OP_MULX;
			S_WRX:    ctrl.op = OP_WRX;
			S_MULR:   ctrl.op = OP_MULR;
			S_WRR:    ctrl.op = OP_WRR;
			S_EMIT: begin
				if (m_tready) begin
					ctrl.op = OP_SHIFTX;
				end
			end
			default: ctrl.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maxit_q <= 16'd8;
			eps_q   <= 32'd1;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_MAX_ITER) begin
				maxit_q <= cfg_data[15:0];
			end else if (cfg_index == REG_EPS) begin
				eps_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
			dsel_q  <= DOT_RR;
			gam_q   <= 1'b0;
			conv_q  <= 1'b0;
			pass_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid && s_tuser == FUNC_START) begin
						state_q <= S_INIT;
					end
				end
				S_INIT: begin
					pass_q  <= '0;
					dsel_q  <= DOT_RR;
					state_q <= S_DOT;
				end
				S_DOT: begin
					cnt_q   <= CW'(1);
					ret_q   <= S_DSHIFT;
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (cnt_q == '0) begin
						cnt_q   <= CW'(DIM - 1);
						state_q <= ret_q;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				S_DSHIFT: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						case (dsel_q)
							DOT_RR: begin
								conv_q <= rr_ok;
								if (pass_q >= maxit_q || rr_ok) begin
									idx_q   <= '0;
									state_q <= S_EMIT;
								end else begin
									gam_q   <= (pass_q != '0);
									state_q <= S_LOADV;
								end
							end
							DOT_PAP: begin
								if (dsum == '0) begin
									idx_q   <= '0;
									state_q <= S_EMIT;
								end else begin
									dsel_q  <= gam_q ? DOT_PAR : DOT_PR;
									state_q <= S_DOT;
								end
							end
							default: begin
								state_q <= S_DIV;
							end
						endcase
					end
				end
				S_LOADV: begin
					cnt_q   <= CW'(DIM - 1);
					state_q <= S_MAC;
				end
				S_MAC: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						cnt_q   <= CW'(1);
						ret_q   <= S_STORE;
						state_q <= S_WAIT;
					end
				end
				S_STORE: begin
					dsel_q  <= DOT_PAP;
					state_q <= S_DOT;
				end
				S_DIV: state_q <= S_DIVWAIT;
				S_DIVWAIT: begin
					if (div_done) begin
						state_q <= gam_q ? S_MULP : S_MULX;
					end
				end
				S_MULP: begin
					cnt_q   <= CW'(1);
					ret_q   <= S_WRP;
					state_q <= S_WAIT;
				end
				S_WRP: begin
					gam_q   <= 1'b0;
					state_q <= S_LOADV;
				end
				S_MULX: begin
					cnt_q   <= CW'(1);
					ret_q   <= S_WRX;
					state_q <= S_WAIT;
				end
				S_WRX: state_q <= S_MULR;
				S_MULR: begin
					cnt_q   <= CW'(1);
					ret_q   <= S_WRR;
					state_q <= S_WAIT;
				end
				S_WRR: begin
					pass_q  <= pass_q + 1'b1;
					dsel_q  <= DOT_RR;
					state_q <= S_DOT;
				end
				S_EMIT: begin
					if (m_tready) begin
						idx_q <= idx_q + 1'b1;
						if (32'(idx_q) == DIM - 1) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DOT) begin
			acc_q <= '0;
		end else if (state_q == S_DSHIFT) begin
			acc_q <= dsum;
			if (cnt_q == '0) begin
				if (dsel_q == DOT_PAP) begin
					den_q <= dsum;
				end else if (dsel_q == DOT_PAR) begin
					num_q <= -dsum;
				end else if (dsel_q == DOT_PR) begin
					num_q <= dsum;
				end
			end
		end
		if (state_q == S_DIVWAIT && div_done) begin
			scal_q <= div_quo;
		end
	end

	for (genvar i = 0; i < DIM; i++) begin : g_cell
		logic signed [ACC_W-1:0] t_nb;
		logic signed [VAL_W-1:0] x_nb;
		if (i == DIM - 1) begin : g_end
			assign t_nb = '0;
			assign x_nb = '0;
		end else begin : g_mid
			assign t_nb = t_o[i+1];
			assign x_nb = x_o[i+1];
		end
		cgs_cell #(
			.DIM       (DIM),
			.FRAC_BITS (FRAC_BITS),
			.CELL_IDX  (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.v_in   (v_o[(i + 1) % DIM]),
			.v_out  (v_o[i]),
			.t_in   (t_nb),
			.t_out  (t_o[i]),
			.x_in   (x_nb),
			.x_out  (x_o[i])
		);
	end

	cgs_div #(
		.FRAC_BITS (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_q),
		.den    (den_q),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	`CGS_ASSERT_NXT(a_start_blocks, s_tvalid && s_tready && s_tuser == FUNC_START, !s_tready, "start request did not block input")
	`CGS_ASSERT_IMP(a_emit_busy, m_tvalid, !s_tready, "input open while results pending")
	`CGS_ASSERT_IMP(a_div_idle, div_start, !div_busy, "divider restarted while busy")
	`CGS_ASSERT_IMP(a_done_wait, div_done, state_q == S_DIVWAIT, "quotient arrived outside wait")

endmodule
